// ===== rtl/core/gyro_bias_observability_gate_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the gyro bias observability gate
// Concurrent checks clocked on clk, with and without the reset guard.
// ----------------------------------------------------------------------------
`ifndef GYRO_BIAS_OBSERVABILITY_GATE_CORE_ASSERT_SVH
`define GYRO_BIAS_OBSERVABILITY_GATE_CORE_ASSERT_SVH

// Check a property outside reset.
`define GBOG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property at every edge, reset included.
`define GBOG_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/gbog_pkg.sv =====
// ----------------------------------------------------------------------------
// gbog_pkg
// Shared types and constants of the gyro bias observability gate.
// ----------------------------------------------------------------------------
package gbog_pkg;

    typedef logic [1:0] reg_idx_t;

    localparam reg_idx_t REG_SPEED_MIN  = 2'd0;
    localparam reg_idx_t REG_YAW_MIN    = 2'd1;
    localparam reg_idx_t REG_LAT_MIN    = 2'd2;
    localparam reg_idx_t REG_GATE_FLOOR = 2'd3;

    localparam logic [16:0]        SCORE_ONE   = 17'd65536;
    localparam logic [30:0]        MEAS_MAX    = 31'h7FFF_FFFF;
    localparam logic signed [31:0] Q30_POS     = 32'sh4000_0000;
    localparam logic signed [31:0] Q30_NEG     = 32'shC000_0000;
    localparam logic [29:0]        NS_PER_S    = 30'd1000000000;
    // pi/180 in Q0.32
    localparam logic [26:0]        DEG2RAD_Q32 = 27'd74961321;

    typedef struct packed {
        logic        valid_res;
        logic [30:0] fwd;
        logic [30:0] yaw;
        logic [30:0] lat;
        logic [16:0] gate;
    } res_t;

endpackage

// ===== rtl/core/gyro_bias_observability_gate_core.sv =====
// ----------------------------------------------------------------------------
// gyro_bias_observability_gate_core
// Scores forward speed, yaw rate and lateral acceleration of one inertial
// sample and forms the gyro z bias observability gate.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | into core | in_valid / in_stall  | quaternion, velocity,
//          |           |                      | dtheta_z, dvel_y, interval_ns
//  out     | from core | out_valid / out_stall| valid_res, three measures,
//          |           |                      | gate_factor
//  cfg     | into core | cfg_we               | cfg_idx, cfg_data
//
//  One request is taken every cycle while in_stall is low; on its way to the
//  output register a request passes two chains of one-bit restoring divider
//  stages (31 for the measures, 17 for the scores).
//  Reset clears the valid bits of the pipeline, the output register and the
//  skid entry, and the configuration registers; no clearing pass is needed.
//  A stalled output parks one result in the skid entry; in_stall then rises
//  and the whole pipeline holds until the skid entry drains.
// ----------------------------------------------------------------------------
module gyro_bias_observability_gate_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  gbog_pkg::reg_idx_t       cfg_idx,
    input  logic [30:0]              cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [31:0]       quat_w,
    input  logic signed [31:0]       quat_x,
    input  logic signed [31:0]       quat_y,
    input  logic signed [31:0]       quat_z,
    input  logic signed [31:0]       vel_north,
    input  logic signed [31:0]       vel_east,
    input  logic signed [31:0]       vel_down,
    input  logic signed [31:0]       dtheta_z,
    input  logic signed [31:0]       dvel_y,
    input  logic [31:0]              interval_ns,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     valid_res,
    output logic [30:0]              fwd_speed_mag,
    output logic [30:0]              yaw_rate_mag,
    output logic [30:0]              lat_acc_mag,
    output logic [16:0]              gate_factor
);
    import gbog_pkg::*;

    // Stage map: 1 input, 2 products, 3 rotation column and divider set-up,
    // 4..34 measure division, 35 score set-up, 36..52 score division,
    // 53 gate product, 54 final result.
    localparam int DIV_STEPS   = 31;
    localparam int SCORE_STEPS = 17;
    localparam int T_SINIT     = 3 + DIV_STEPS + 1;
    localparam int T_MUL       = T_SINIT + SCORE_STEPS + 1;
    localparam int N_ST        = T_MUL + 1;
    localparam int FWD_DLY     = T_SINIT - 6;
    localparam int MEAS_ST     = T_MUL - T_SINIT + 1;

    // ------------------------------------------------------------------
    // Configuration registers and derived divisors
    // ------------------------------------------------------------------
    logic [30:0] spd_min_reg;
    logic [30:0] yaw_min_reg;
    logic [30:0] lat_min_reg;
    logic [16:0] floor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spd_min_reg <= 31'd65536;
            yaw_min_reg <= 31'd65536;
            lat_min_reg <= 31'd65536;
            floor_reg   <= 17'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_SPEED_MIN:  spd_min_reg <= cfg_data;
                REG_YAW_MIN:    yaw_min_reg <= cfg_data;
                REG_LAT_MIN:    lat_min_reg <= cfg_data;
                REG_GATE_FLOOR: floor_reg   <= cfg_data[16:0];
                default:        floor_reg   <= floor_reg;
            endcase
        end
    end

    // Convert the yaw minimum from deg/s to rad/s with rounding; a minimum that
    // converts to zero counts as one least significant bit. Settles long before any
    // request reaches the score stages.
    logic [57:0] yaw_conv_prod;
    logic [57:0] yaw_conv_rnd;
    logic [30:0] div_reg [0:2];

    assign yaw_conv_prod = yaw_min_reg * DEG2RAD_Q32;
    assign yaw_conv_rnd  = yaw_conv_prod + 58'h0_8000_0000;

    always_ff @(posedge clk)
    begin
        div_reg[0] <= (spd_min_reg == 31'd0) ? 31'd1 : spd_min_reg;
        div_reg[1] <= (yaw_conv_rnd[57:32] == 26'd0) ? 31'd1
                                                     : {5'd0, yaw_conv_rnd[57:32]};
        div_reg[2] <= (lat_min_reg == 31'd0) ? 31'd1 : lat_min_reg;
    end

    // ------------------------------------------------------------------
    // Flow control: the pipeline advances while the skid entry is empty
    // ------------------------------------------------------------------
    logic skid_v_reg;
    logic en;
    logic in_acc;

    assign en       = !skid_v_reg;
    assign in_stall = skid_v_reg;
    assign in_acc   = in_valid && !skid_v_reg;

    logic vld_reg [1:N_ST];
    logic inv_reg [1:N_ST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 1; t <= N_ST; t++)
                vld_reg[t] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[1] <= in_acc;
            for (int t = 2; t <= N_ST; t++)
                vld_reg[t] <= vld_reg[t-1];
        end
    end

    // Short interval marker travels beside the valid bit.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inv_reg[1] <= (interval_ns <= 32'd1);
            for (int t = 2; t <= N_ST; t++)
                inv_reg[t] <= inv_reg[t-1];
        end
    end

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] clamp_q(input logic signed [31:0] v);
        logic signed [31:0] r;
        begin
            r = v;
            if (v > Q30_POS)
                r = Q30_POS;
            else if (v < Q30_NEG)
                r = Q30_NEG;
            return r;
        end
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        logic [31:0] r;
        begin
            r = v[31] ? (~v + 32'd1) : v;
            return r;
        end
    endfunction

    // One restoring step, 32-bit divisor: returns {quotient bit, remainder}.
    function automatic logic [32:0] div_step(input logic [31:0] rem,
                                             input logic nb,
                                             input logic [31:0] d);
        logic [32:0] r2;
        logic [32:0] diff;
        logic        ge;
        begin
            r2   = {rem, nb};
            diff = r2 - {1'b0, d};
            ge   = (r2 >= {1'b0, d});
            return {ge, ge ? diff[31:0] : r2[31:0]};
        end
    endfunction

    // One restoring step, 31-bit divisor.
    function automatic logic [31:0] score_step(input logic [30:0] rem,
                                               input logic nb,
                                               input logic [30:0] d);
        logic [31:0] r2;
        logic [31:0] diff;
        logic        ge;
        begin
            r2   = {rem, nb};
            diff = r2 - {1'b0, d};
            ge   = (r2 >= {1'b0, d});
            return {ge, ge ? diff[30:0] : r2[30:0]};
        end
    endfunction

    // ------------------------------------------------------------------
    // Stage 1: saturate the quaternion, take magnitudes of the increments
    // ------------------------------------------------------------------
    logic signed [31:0] q1_reg [0:3];
    logic signed [31:0] v1_reg [0:2];
    logic [31:0]        dth_abs1_reg;
    logic [31:0]        dv_abs1_reg;
    logic [31:0]        dt1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_reg[0]    <= clamp_q(quat_w);
            q1_reg[1]    <= clamp_q(quat_x);
            q1_reg[2]    <= clamp_q(quat_y);
            q1_reg[3]    <= clamp_q(quat_z);
            v1_reg[0]    <= vel_north;
            v1_reg[1]    <= vel_east;
            v1_reg[2]    <= vel_down;
            dth_abs1_reg <= abs32(dtheta_z);
            dv_abs1_reg  <= abs32(dvel_y);
            dt1_reg      <= interval_ns;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: quaternion products and scaling by 1e9
    // ------------------------------------------------------------------
    // order: ww, xx, yy, zz, xy, wz, xz, wy
    logic signed [63:0] p2_reg [0:7];
    logic signed [31:0] v2_reg [0:2];
    logic [61:0]        ny2_reg;
    logic [61:0]        nl2_reg;
    logic [31:0]        dt2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_reg[0] <= q1_reg[0] * q1_reg[0];
            p2_reg[1] <= q1_reg[1] * q1_reg[1];
            p2_reg[2] <= q1_reg[2] * q1_reg[2];
            p2_reg[3] <= q1_reg[3] * q1_reg[3];
            p2_reg[4] <= q1_reg[1] * q1_reg[2];
            p2_reg[5] <= q1_reg[0] * q1_reg[3];
            p2_reg[6] <= q1_reg[1] * q1_reg[3];
            p2_reg[7] <= q1_reg[0] * q1_reg[2];
            v2_reg    <= v1_reg;
            ny2_reg   <= dth_abs1_reg * NS_PER_S;
            nl2_reg   <= dv_abs1_reg * NS_PER_S;
            dt2_reg   <= dt1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: first body-axis column in Q.28, divider set-up
    // ------------------------------------------------------------------
    logic signed [63:0] c1_sum;
    logic signed [63:0] c2_sum;
    logic signed [63:0] c3_sum;
    logic signed [63:0] c1_sh;
    logic signed [63:0] c2_sh;
    logic signed [63:0] c3_sh;
    logic [47:0]        ny_sh;

    assign c1_sum = p2_reg[0] + p2_reg[1] - p2_reg[2] - p2_reg[3];
    assign c2_sum = p2_reg[4] + p2_reg[5];
    assign c3_sum = p2_reg[6] - p2_reg[7];
    // doubling then dropping 32 bits is dropping 31
    assign c1_sh  = c1_sum >>> 32;
    assign c2_sh  = c2_sum >>> 31;
    assign c3_sh  = c3_sum >>> 31;
    // yaw divides by interval * 2^14: drop 14 bits first, the floors nest
    assign ny_sh  = ny2_reg[61:14];

    logic signed [31:0] c3_reg [0:2];
    logic signed [31:0] v3_reg [0:2];

    // Divider pipeline, lane 0 yaw rate, lane 1 lateral acceleration.
    // Index k sits in stage 3 + k.
    logic [31:0] dv_rem_reg [0:DIV_STEPS-1][0:1];
    logic [30:0] dv_low_reg [0:DIV_STEPS-1][0:1];
    logic [30:0] dv_q_reg   [0:DIV_STEPS][0:1];
    logic        dv_ovf_reg [0:DIV_STEPS][0:1];
    logic [31:0] dv_dt_reg  [0:DIV_STEPS-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c3_reg[0] <= c1_sh[31:0];
            c3_reg[1] <= c2_sh[31:0];
            c3_reg[2] <= c3_sh[31:0];
            v3_reg    <= v2_reg;

            // Quotient saturates at 31 bits: flag it when the high part
            // already reaches the divisor.
            dv_ovf_reg[0][0] <= ({15'd0, ny_sh[47:31]} >= dt2_reg);
            dv_rem_reg[0][0] <= {15'd0, ny_sh[47:31]};
            dv_low_reg[0][0] <= ny_sh[30:0];
            dv_q_reg[0][0]   <= 31'd0;
            dv_ovf_reg[0][1] <= ({1'b0, nl2_reg[61:31]} >= dt2_reg);
            dv_rem_reg[0][1] <= {1'b0, nl2_reg[61:31]};
            dv_low_reg[0][1] <= nl2_reg[30:0];
            dv_q_reg[0][1]   <= 31'd0;
            dv_dt_reg[0]     <= dt2_reg;

            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                for (int l = 0; l < 2; l++)
                begin
                    logic [32:0] st;
                    st = div_step(dv_rem_reg[k-1][l], dv_low_reg[k-1][l][30],
                                  dv_dt_reg[k-1]);
                    dv_q_reg[k][l]   <= {dv_q_reg[k-1][l][29:0], st[32]};
                    dv_ovf_reg[k][l] <= dv_ovf_reg[k-1][l];
                    if (k < DIV_STEPS)
                    begin
                        dv_rem_reg[k][l] <= st[31:0];
                        dv_low_reg[k][l] <= {dv_low_reg[k-1][l][29:0], 1'b0};
                    end
                end
                if (k < DIV_STEPS)
                    dv_dt_reg[k] <= dv_dt_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 4 and 5: body forward speed, then delay it to the scores
    // ------------------------------------------------------------------
    logic signed [63:0] cv4_reg [0:2];
    logic signed [63:0] vb_sum;
    logic signed [63:0] vb_sh;
    logic [63:0]        vb_abs;
    logic [30:0]        fwd5_reg;
    logic [30:0]        fwd_dly_reg [0:FWD_DLY-1];

    assign vb_sum = cv4_reg[0] + cv4_reg[1] + cv4_reg[2];
    assign vb_sh  = vb_sum >>> 28;
    assign vb_abs = vb_sh[63] ? (~vb_sh + 64'd1) : vb_sh;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                cv4_reg[i] <= c3_reg[i] * v3_reg[i];
            fwd5_reg       <= (vb_abs > {33'd0, MEAS_MAX}) ? MEAS_MAX : vb_abs[30:0];
            fwd_dly_reg[0] <= fwd5_reg;
            for (int j = 1; j < FWD_DLY; j++)
                fwd_dly_reg[j] <= fwd_dly_reg[j-1];
        end
    end

    // ------------------------------------------------------------------
    // Stages 35..52: scores, lane 0 speed, 1 yaw, 2 lateral
    // ------------------------------------------------------------------
    logic [30:0] meas_in [0:2];

    assign meas_in[0] = fwd_dly_reg[FWD_DLY-1];
    assign meas_in[1] = dv_ovf_reg[DIV_STEPS][0] ? MEAS_MAX : dv_q_reg[DIV_STEPS][0];
    assign meas_in[2] = dv_ovf_reg[DIV_STEPS][1] ? MEAS_MAX : dv_q_reg[DIV_STEPS][1];

    logic [30:0] meas_reg [0:MEAS_ST-1][0:2];
    logic [30:0] sc_rem_reg [0:SCORE_STEPS-1][0:2];
    logic [16:0] sc_q_reg   [0:SCORE_STEPS][0:2];
    logic        sc_sat_reg [0:SCORE_STEPS][0:2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                meas_reg[0][l] <= meas_in[l];
                // quotient of meas*2^16 reaches 2^17 once meas >= 2*divisor
                sc_sat_reg[0][l] <= ({1'b0, meas_in[l]} >= {div_reg[l], 1'b0});
                sc_rem_reg[0][l] <= {1'b0, meas_in[l][30:1]};
                sc_q_reg[0][l]   <= 17'd0;
                for (int m = 1; m < MEAS_ST; m++)
                    meas_reg[m][l] <= meas_reg[m-1][l];
                for (int j = 1; j <= SCORE_STEPS; j++)
                begin
                    logic [31:0] st;
                    logic        nb;
                    // the lowest measure bit comes in first, then zeros
                    nb = (j == 1) ? meas_reg[0][l][0] : 1'b0;
                    st = score_step(sc_rem_reg[j-1][l], nb, div_reg[l]);
                    sc_q_reg[j][l]   <= {sc_q_reg[j-1][l][15:0], st[31]};
                    sc_sat_reg[j][l] <= sc_sat_reg[j-1][l];
                    if (j < SCORE_STEPS)
                        sc_rem_reg[j][l] <= st[30:0];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 53: clamp scores, pick the larger turn score, multiply
    // ------------------------------------------------------------------
    logic [16:0] score [0:2];
    logic [16:0] turn;
    logic [33:0] gp_reg;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
            score[l] = (sc_sat_reg[SCORE_STEPS][l] ||
                        sc_q_reg[SCORE_STEPS][l] > SCORE_ONE) ? SCORE_ONE
                                                              : sc_q_reg[SCORE_STEPS][l];
        turn = (score[1] > score[2]) ? score[1] : score[2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            gp_reg <= score[0] * turn;
    end

    // ------------------------------------------------------------------
    // Stage 54: floor and clamp the gate, build the result
    // ------------------------------------------------------------------
    logic [17:0] gate_raw;
    logic [17:0] gate_flr;
    logic [16:0] gate_fin;
    res_t        res_next;
    res_t        res_reg;

    always_comb
    begin
        gate_raw = gp_reg[33:16];
        gate_flr = (gate_raw < {1'b0, floor_reg}) ? {1'b0, floor_reg} : gate_raw;
        gate_fin = (gate_flr > {1'b0, SCORE_ONE}) ? SCORE_ONE : gate_flr[16:0];
        if (inv_reg[T_MUL])
        begin
            // short interval: drop the measures, assume full gate
            res_next.valid_res = 1'b0;
            res_next.fwd       = 31'd0;
            res_next.yaw       = 31'd0;
            res_next.lat       = 31'd0;
            res_next.gate      = SCORE_ONE;
        end
        else
        begin
            res_next.valid_res = 1'b1;
            res_next.fwd       = meas_reg[MEAS_ST-1][0];
            res_next.yaw       = meas_reg[MEAS_ST-1][1];
            res_next.lat       = meas_reg[MEAS_ST-1][2];
            res_next.gate      = gate_fin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    // ------------------------------------------------------------------
    // Output register and skid entry
    // ------------------------------------------------------------------
    logic out_v_reg;
    logic out_v_next;
    logic skid_v_next;
    res_t out_d_reg;
    res_t out_d_next;
    res_t skid_d_reg;
    res_t skid_d_next;

    always_comb
    begin
        out_v_next  = out_v_reg;
        out_d_next  = out_d_reg;
        skid_v_next = skid_v_reg;
        skid_d_next = skid_d_reg;
        if (skid_v_reg)
        begin
            // pipeline holds; drain the skid entry when the output frees
            if (!out_v_reg || !out_stall)
            begin
                out_v_next  = 1'b1;
                out_d_next  = skid_d_reg;
                skid_v_next = 1'b0;
            end
        end
        else if (!out_v_reg || !out_stall)
        begin
            out_v_next = vld_reg[N_ST];
            out_d_next = res_reg;
        end
        else if (vld_reg[N_ST])
        begin
            // output stalled: park the arriving request
            skid_v_next = 1'b1;
            skid_d_next = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_d_reg  <= out_d_next;
        skid_d_reg <= skid_d_next;
    end

    assign out_valid     = out_v_reg;
    assign valid_res     = out_d_reg.valid_res;
    assign fwd_speed_mag = out_d_reg.fwd;
    assign yaw_rate_mag  = out_d_reg.yaw;
    assign lat_acc_mag   = out_d_reg.lat;
    assign gate_factor   = out_d_reg.gate;

endmodule

// ===== rtl/core/gbog_chk.sv =====
// ----------------------------------------------------------------------------
// gbog_chk
// Port-level checks of the gyro bias observability gate, bound to the core.
// ----------------------------------------------------------------------------
`include "gyro_bias_observability_gate_core_assert.svh"

module gbog_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        valid_res,
    input logic [30:0] fwd_speed_mag,
    input logic [30:0] yaw_rate_mag,
    input logic [30:0] lat_acc_mag,
    input logic [16:0] gate_factor
);
    import gbog_pkg::*;

    logic         out_held;
    logic         short_ok;
    logic [110:0] out_payload;

    assign out_held    = out_valid && out_stall;
    assign out_payload = {valid_res, fwd_speed_mag, yaw_rate_mag, lat_acc_mag, gate_factor};
    assign short_ok    = gate_factor == SCORE_ONE && fwd_speed_mag == 31'd0 &&
                         yaw_rate_mag == 31'd0 && lat_acc_mag == 31'd0;

    // reset empties the output and the skid entry by the following edge
    `GBOG_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid && !in_stall, "not empty after reset")

    `GBOG_ASSERT(a_out_hold, out_held |=> out_valid && $stable(out_payload), "stalled request changed")

    // short interval requests carry zero measures and a full gate
    `GBOG_ASSERT(a_invalid_res, out_valid && !valid_res |-> short_ok, "bad short interval result")

    `GBOG_ASSERT(a_gate_range, out_valid |-> gate_factor <= SCORE_ONE, "gate above one")

endmodule

bind gyro_bias_observability_gate_core gbog_chk u_gbog_chk (.*);

// ===== tb/gyro_bias_observability_gate_core_checker.sv =====
// ----------------------------------------------------------------------------
// gyro_bias_observability_gate_core_checker
// Watches the configuration port and both request channels of the gate core,
// predicts each result from the accepted sample and compares it field by
// field with what the core delivers, in order.
// ----------------------------------------------------------------------------
module gyro_bias_observability_gate_core_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  gbog_pkg::reg_idx_t cfg_idx,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [31:0] quat_w,
    input  logic signed [31:0] quat_x,
    input  logic signed [31:0] quat_y,
    input  logic signed [31:0] quat_z,
    input  logic signed [31:0] vel_north,
    input  logic signed [31:0] vel_east,
    input  logic signed [31:0] vel_down,
    input  logic signed [31:0] dtheta_z,
    input  logic signed [31:0] dvel_y,
    input  logic [31:0]        interval_ns,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               valid_res,
    input  logic [30:0]        fwd_speed_mag,
    input  logic [30:0]        yaw_rate_mag,
    input  logic [30:0]        lat_acc_mag,
    input  logic [16:0]        gate_factor,
    output int                 fail_count,
    output int                 pending_count
);
    import gbog_pkg::*;

    logic [63:0] speed_min_q;
    logic [63:0] yaw_min_deg_q;
    logic [63:0] lat_min_q;
    logic [63:0] floor_q;
    res_t        gate_results_due[$];

    function automatic longint sat_q30(input logic signed [31:0] v);
        longint s;
        s = longint'(v);
        if (s > 64'sd1073741824)
            s = 64'sd1073741824;
        if (s < -64'sd1073741824)
            s = -64'sd1073741824;
        return s;
    endfunction

    function automatic logic [63:0] sat_meas(input logic [63:0] v);
        return (v > 64'd2147483647) ? 64'd2147483647 : v;
    endfunction

    function automatic logic [63:0] score(input logic [63:0] meas,
                                          input logic [63:0] minimum);
        logic [63:0] d;
        logic [63:0] s;
        d = (minimum == 0) ? 64'd1 : minimum;
        s = (meas << 16) / d;
        return (s > 64'd65536) ? 64'd65536 : s;
    endfunction

    function automatic res_t predict_gate(input logic signed [31:0] qw, qx, qy, qz,
                                          input logic signed [31:0] vn, ve, vd,
                                          input logic signed [31:0] dth, dv,
                                          input logic [31:0] dt);
        res_t        r;
        longint      w, x, y, z, c1, c2, c3, vb, ath, adv;
        logic [63:0] fwd, yaw, lat, yaw_min, s_sp, s_yaw, s_lat, turn, gate;
        if (dt <= 32'd1)
        begin
            r.valid_res = 1'b0;
            r.fwd       = '0;
            r.yaw       = '0;
            r.lat       = '0;
            r.gate      = SCORE_ONE;
            return r;
        end
        w  = sat_q30(qw);
        x  = sat_q30(qx);
        y  = sat_q30(qy);
        z  = sat_q30(qz);
        // body x column of the rotation, floor to Q.28
        c1 = (w * w + x * x - y * y - z * z) >>> 32;
        c2 = (2 * (x * y + w * z)) >>> 32;
        c3 = (2 * (x * z - w * y)) >>> 32;
        vb = (c1 * longint'(vn) + c2 * longint'(ve) + c3 * longint'(vd)) >>> 28;
        fwd = sat_meas((vb < 0) ? 64'(-vb) : 64'(vb));
        ath = (dth < 0) ? -longint'(dth) : longint'(dth);
        adv = (dv < 0) ? -longint'(dv) : longint'(dv);
        yaw = sat_meas((64'(ath) * 64'd1000000000) / ({32'b0, dt} << 14));
        lat = sat_meas((64'(adv) * 64'd1000000000) / {32'b0, dt});
        yaw_min = (yaw_min_deg_q * 64'd74961321 + 64'h8000_0000) >> 32;
        s_sp  = score(fwd, speed_min_q);
        s_yaw = score(yaw, yaw_min);
        s_lat = score(lat, lat_min_q);
        turn  = (s_yaw > s_lat) ? s_yaw : s_lat;
        gate  = (s_sp * turn) >> 16;
        if (gate < floor_q)
            gate = floor_q;
        if (gate > 64'd65536)
            gate = 64'd65536;
        r.valid_res = 1'b1;
        r.fwd       = fwd[30:0];
        r.yaw       = yaw[30:0];
        r.lat       = lat[30:0];
        r.gate      = gate[16:0];
        return r;
    endfunction

    assign pending_count = gate_results_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            speed_min_q   <= 64'd65536;
            yaw_min_deg_q <= 64'd65536;
            lat_min_q     <= 64'd65536;
            floor_q       <= 64'd0;
            fail_count    <= 0;
            gate_results_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_SPEED_MIN:  speed_min_q   <= {33'b0, cfg_data};
                    REG_YAW_MIN:    yaw_min_deg_q <= {33'b0, cfg_data};
                    REG_LAT_MIN:    lat_min_q     <= {33'b0, cfg_data};
                    REG_GATE_FLOOR: floor_q       <= {47'b0, cfg_data[16:0]};
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                gate_results_due.push_back(predict_gate(quat_w, quat_x, quat_y, quat_z,
                    vel_north, vel_east, vel_down, dtheta_z, dvel_y, interval_ns));
            if (out_valid && !out_stall)
            begin
                if (gate_results_due.size() == 0)
                begin
                    $display("%0t: result with nothing expected", $time);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = gate_results_due.pop_front();
                    if (want.valid_res !== valid_res || want.fwd !== fwd_speed_mag ||
                        want.yaw !== yaw_rate_mag || want.lat !== lat_acc_mag ||
                        want.gate !== gate_factor)
                    begin
                        $display("%0t: mismatch expected v=%0d fwd=%0d yaw=%0d lat=%0d gate=%0d",
                                 $time, want.valid_res, want.fwd, want.yaw, want.lat,
                                 want.gate);
                        $display("%0t:          actual   v=%0d fwd=%0d yaw=%0d lat=%0d gate=%0d",
                                 $time, valid_res, fwd_speed_mag, yaw_rate_mag,
                                 lat_acc_mag, gate_factor);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/gyro_bias_observability_gate_core_test.sv =====
// ----------------------------------------------------------------------------
// gyro_bias_observability_gate_core_test
// Drives the gate core with directed and random inertial samples over several
// register settings, with bursty requests and a stalling receiver; the
// checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module gyro_bias_observability_gate_core_test;
    import gbog_pkg::*;

    localparam int LATENCY_WAIT = 80;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    reg_idx_t           cfg_idx;
    logic [30:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] quat_w, quat_x, quat_y, quat_z;
    logic signed [31:0] vel_north, vel_east, vel_down;
    logic signed [31:0] dtheta_z, dvel_y;
    logic [31:0]        interval_ns;
    logic               out_valid;
    logic               out_stall;
    logic               valid_res;
    logic [30:0]        fwd_speed_mag, yaw_rate_mag, lat_acc_mag;
    logic [16:0]        gate_factor;
    int                 fail_count;
    int                 pending_count;
    int                 burst_left;
    int                 stall_pct;
    int                 stall_age;

    gyro_bias_observability_gate_core i_dut (.*);

    gyro_bias_observability_gate_core_checker i_checker (.*);

    // 20 time unit clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Receiver: change stall density every so often, including spells of none
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_pct <= 0;
            stall_age <= 0;
        end
        else
        begin
            if (stall_age == 0)
            begin
                case ($urandom_range(0, 3))
                    0: stall_pct <= 0;
                    1: stall_pct <= 20;
                    2: stall_pct <= 50;
                    default: stall_pct <= 85;
                endcase
                stall_age <= $urandom_range(20, 300);
            end
            else
                stall_age <= stall_age - 1;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Hard stop in case the core hangs
    initial
    begin
        #8000000;
        $display("[gyro_bias_observability_gate_core] ERROR");
        $finish;
    end

    // Hold the request until taken; open a gap between bursts
    task automatic send_sample(input logic signed [31:0] qw, qx, qy, qz,
                               input logic signed [31:0] vn, ve, vd, dth, dv,
                               input logic [31:0] dt);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 30);
        end
        burst_left = burst_left - 1;
        in_valid    <= 1'b1;
        quat_w      <= qw;
        quat_x      <= qx;
        quat_y      <= qy;
        quat_z      <= qz;
        vel_north   <= vn;
        vel_east    <= ve;
        vel_down    <= vd;
        dtheta_z    <= dth;
        dvel_y      <= dv;
        interval_ns <= dt;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid and wait for every outstanding result, then for the pipe
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    // One write, then the enable drops before the next one
    task automatic write_reg(input reg_idx_t idx, input logic [30:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_quat();
        // mostly inside [-1,1], sometimes any pattern to hit saturation
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
    endfunction

    function automatic logic signed [31:0] rand_wide();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            2: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            default: return $signed($urandom_range(0, 32'h2000)) - 32'sh1000;
        endcase
    endfunction

    function automatic logic [31:0] rand_interval();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 2);
            1: return $urandom_range(3, 1000);
            2: return $urandom;
            3: return 32'hFFFF_FFFF;
            default: return $urandom_range(100000, 20000000);
        endcase
    endfunction

    function automatic logic [30:0] rand_min();
        case ($urandom_range(0, 3))
            0: return 31'($urandom_range(0, 3));
            1: return 31'($urandom);
            default: return 31'($urandom_range(1000, 2000000));
        endcase
    endfunction

    task automatic random_batch(input int count, input bit hold_midway);
        for (int i = 0; i < count; i++)
        begin
            if (hold_midway && i == count / 2)
                drain();
            send_sample(rand_quat(), rand_quat(), rand_quat(), rand_quat(),
                        rand_wide(), rand_wide(), rand_wide(), rand_wide(), rand_wide(),
                        rand_interval());
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_idx     = REG_SPEED_MIN;
        cfg_data    = '0;
        in_valid    = 1'b0;
        quat_w      = '0;
        quat_x      = '0;
        quat_y      = '0;
        quat_z      = '0;
        vel_north   = '0;
        vel_east    = '0;
        vel_down    = '0;
        dtheta_z    = '0;
        dvel_y      = '0;
        interval_ns = '0;
        burst_left  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: short intervals, field extremes, saturation of quaternion
        send_sample(32'sh4000_0000, 0, 0, 0, 32'sh0001_0000, 0, 0, 0, 0, 0);
        send_sample(32'sh4000_0000, 0, 0, 0, 32'sh0001_0000, 0, 0, 0, 0, 1);
        send_sample(32'sh4000_0000, 0, 0, 0, 32'sh0001_0000, 0, 0, 32'sh0000_1000, 0, 2);
        send_sample(32'sh4000_0000, 0, 0, 0, 32'sh7FFF_FFFF, 0, 0, 0, 0, 10000000);
        send_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                    32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                    32'sh8000_0000, 32'sh7FFF_FFFF, 2);
        send_sample(32'shC000_0000, 32'shC000_0000, 32'sh4000_0000, 32'sh4000_0000,
                    32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                    32'sh7FFF_FFFF, 32'sh8000_0000, 32'hFFFF_FFFF);
        send_sample(32'sh2D41_3CCD, 0, 0, 32'sh2D41_3CCD, 32'sh0005_0000, 32'sh0003_0000,
                    32'shFFFF_0000, 32'sh0001_0000, 32'sh0002_0000, 10000000);
        send_sample(0, 32'sh4000_0000, 0, 0, 32'shFFFB_0000, 0, 0,
                    32'shFFFF_0000, 32'shFFFE_0000, 5000000);
        send_sample(0, 0, 32'sh4000_0000, 0, 0, 0, 32'sh0010_0000, 0, 32'sh0000_8000, 1000);
        send_sample(0, 0, 0, 32'sh4000_0000, 32'sh0002_0000, 32'sh0002_0000,
                    32'sh0002_0000, 32'sh0000_0100, 32'sh0000_0100, 100000000);
        send_sample(0, 0, 0, 0, 32'sh0100_0000, 32'sh0100_0000, 32'sh0100_0000,
                    32'sh0000_0001, 32'sh0000_0001, 3);
        send_sample(32'sh4000_0000, 0, 0, 0, 32'sh0000_0001, 0, 0, 32'sh0000_0010,
                    32'sh0000_0010, 32'h8000_0000);
        drain();

        // Zero minima count as one LSB; floor at one
        write_reg(REG_SPEED_MIN, 31'd0);
        write_reg(REG_YAW_MIN, 31'd0);
        write_reg(REG_LAT_MIN, 31'd0);
        write_reg(REG_GATE_FLOOR, 31'd65536);
        random_batch(250, 1'b0);
        drain();

        // Largest minima; floor pattern above one (upper bits dropped)
        write_reg(REG_SPEED_MIN, 31'h7FFF_FFFF);
        write_reg(REG_YAW_MIN, 31'h7FFF_FFFF);
        write_reg(REG_LAT_MIN, 31'h7FFF_FFFF);
        write_reg(REG_GATE_FLOOR, 31'h7FFF_FFFF);
        random_batch(250, 1'b0);
        drain();

        // Yaw minimum that converts to zero, floor just over one
        write_reg(REG_SPEED_MIN, 31'd1);
        write_reg(REG_YAW_MIN, 31'd28);
        write_reg(REG_LAT_MIN, 31'd1);
        write_reg(REG_GATE_FLOOR, 31'd65537);
        random_batch(250, 1'b1);
        drain();

        // Several random settings with realistic content
        for (int p = 0; p < 4; p++)
        begin
            write_reg(REG_SPEED_MIN, rand_min());
            write_reg(REG_YAW_MIN, rand_min());
            write_reg(REG_LAT_MIN, rand_min());
            write_reg(REG_GATE_FLOOR, 31'($urandom_range(0, 70000)));
            random_batch(290, p == 1);
            drain();
        end

        if (fail_count == 0)
            $display("[gyro_bias_observability_gate_core] OK");
        else
            $display("[gyro_bias_observability_gate_core] ERROR");
        $finish;
    end

endmodule
